### hdl/ncr_pkg.sv
// Shared types and constants of the NMEA command receiver with PGN filter.
package ncr_pkg;

    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,
        OP_QUERY      = 2'd1,
        OP_CONNECT    = 2'd2,
        OP_DISCONNECT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_FILTER   = 3'd1,
        EV_UNKNOWN  = 3'd2,
        EV_UNRECOG  = 3'd3,
        EV_CHECKSUM = 3'd4,
        EV_QUERY    = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        LINK_OFF      = 2'd0,
        LINK_PLAIN    = 2'd1,
        LINK_FILTERED = 2'd2
    } link_t;

    typedef enum logic [2:0] {
        CS_SCAN = 3'd0,
        CS_STAR = 3'd1,
        CS_ONE  = 3'd2,
        CS_TWO  = 3'd3,
        CS_DEAD = 3'd4
    } cs_phase_t;

    typedef enum logic [2:0] {
        NUM_IDLE = 3'd0,
        NUM_LEAD = 3'd1,
        NUM_POS  = 3'd2,
        NUM_NEG  = 3'd3,
        NUM_DONE = 3'd4
    } num_phase_t;

    localparam int PREFIX_LEN = 7;
    localparam logic [3:0] PREFIX_BAD = 4'd8;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW    = 8'd32;
    localparam logic [7:0] CH_HIGH   = 8'd126;

    localparam logic [31:0] CMD_LOAD_FILTER = 32'd1;

    // filter load broadcast from the front end to the cell row
    typedef struct packed {
        logic        load;
        logic [31:0] value;
        logic        valid;
    } ncr_load_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h24;
            3'd1: c = 8'h50;
            3'd2: c = 8'h43;
            3'd3: c = 8'h44;
            3'd4: c = 8'h43;
            3'd5: c = 8'h4D;
            3'd6: c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_up(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

endpackage

### hdl/ncr_field_cell.sv
// One field cell: parses the decimal value of one comma-led field.
module ncr_field_cell (
    input  logic        aclk,
    input  logic        clear,
    input  logic        start,
    input  logic        active,
    input  logic        feed,
    input  logic [7:0]  c,
    input  ncr_pkg::num_phase_t phase,
    input  logic [31:0] value_in,
    output logic [31:0] value_out
);
    import ncr_pkg::*;

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic [31:0] times_ten;
    logic [31:0] digit;

    assign times_ten = {value_reg[28:0], 3'b000} + {value_reg[30:0], 1'b0};
    assign digit = {28'd0, c[3:0] - CH_ZERO[3:0]};

    always_comb begin
        value_next = value_reg;
        if (clear) begin
            value_next = value_reg;
        end else if (start) begin
            value_next = 32'd0;
        end else if (active && feed && c >= CH_ZERO && c <= CH_NINE &&
                     (phase == NUM_LEAD || phase == NUM_POS || phase == NUM_NEG)) begin
            value_next = (phase == NUM_NEG) ? times_ten - digit : times_ten + digit;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // value_in is unused; value_out always carries this cell's own value_reg
    assign value_out = value_reg ^ (value_in & 32'd0);
endmodule

### hdl/ncr_filter_cell.sv
// One filter cell: holds an entry, takes its load from the top level, ORs matches.
module ncr_filter_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  ncr_pkg::ncr_load_t load_in,
    input  logic [31:0] pgn,
    input  logic        hit_in,
    output logic        hit_out
);
    import ncr_pkg::*;

    logic [31:0] value_reg;
    logic        valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= 32'd0;
            valid_reg <= 1'b0;
        end else if (load_in.load) begin
            value_reg <= load_in.value;
            valid_reg <= load_in.valid;
        end
    end

    assign hit_out = hit_in | (valid_reg && value_reg == pgn);
endmodule

### hdl/nmea_command_receiver_pgn_filter.sv
// Top level: NMEA command line receiver, checksum check and PGN filter.
// Each accepted item's result is registered in the output register, or in the skid buffer
// while the output stalls; one item per cycle is sustained while m_axis_tready is high.
// The line is checked as bytes stream in, with a row of MAX_FIELDS field cells each parsing
// one decimal field and a row of FILTER_ENTRIES filter cells that compare a query PGN in
// parallel. The one-entry skid buffer makes s_axis_tready drop only while two results wait.
module nmea_command_receiver_pgn_filter #(
    parameter int LINE_MAX       = 256,
    parameter int FILTER_ENTRIES = 8,
    parameter int MAX_FIELDS     = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], rx_byte[9:2], pgn[41:10], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_res[2:0], match[3], link_state[5:4], good_lines[37:6],
    // bad_commands[69:38], checksum_errors[101:70], zero fill
    output logic [103:0] m_axis_tdata
);
    import ncr_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX);
    localparam int FC_W  = $clog2(MAX_FIELDS + 1);
    localparam int FN_W  = $clog2(FILTER_ENTRIES + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 2);
    localparam logic [FC_W-1:0]  FC_MAX    = FC_W'(MAX_FIELDS);

    logic [1:0]  in_op;
    logic [7:0]  in_c;
    logic [31:0] in_pgn;
    logic        accept;

    assign in_op  = s_axis_tdata[1:0];
    assign in_c   = s_axis_tdata[9:2];
    assign in_pgn = s_axis_tdata[41:10];

    link_t       link_reg, link_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    cs_phase_t   cs_reg, cs_next;
    logic [7:0]  dig0_reg, dig0_next, dig1_reg, dig1_next;
    logic [3:0]  pre_reg, pre_next;
    logic [FC_W-1:0] fc_reg, fc_next;
    num_phase_t  num_reg, num_next;
    logic        stop_reg, stop_next;
    logic [31:0] good_reg, good_next, badc_reg, badc_next, cerr_reg, cerr_next;
    logic [FN_W-1:0] nvalid_reg, nvalid_next;
    event_t      ev;
    logic        hit;

    logic        feed, line_clear, load_filter;
    logic [MAX_FIELDS-1:0] start_vec, active_vec;
    logic [31:0] fval [MAX_FIELDS];
    logic [31:0] fchain [MAX_FIELDS+1];

    assign fchain[0] = 32'd0;
    for (genvar i = 0; i < MAX_FIELDS; i++) begin : g_field
        ncr_field_cell u_cell (
            .aclk      (aclk),
            .clear     (line_clear),
            .start     (start_vec[i]),
            .active    (active_vec[i]),
            .feed      (feed),
            .c         (in_c),
            .phase     (num_reg),
            .value_in  (fchain[i]),
            .value_out (fval[i])
        );
        assign fchain[i+1] = fval[i];
    end

    ncr_load_t   lds [FILTER_ENTRIES];
    logic        hchain [FILTER_ENTRIES+1];
    assign hchain[0] = 1'b0;
    for (genvar j = 0; j < FILTER_ENTRIES; j++) begin : g_filt
        always_comb begin
            lds[j].load  = load_filter;
            lds[j].valid = (FN_W'(j) < nvalid_next);
            lds[j].value = 32'd0;
            if (j + 1 < MAX_FIELDS && lds[j].valid) begin
                lds[j].value = fval[(j + 1 < MAX_FIELDS) ? j + 1 : 0];
            end
        end
        ncr_filter_cell u_filt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load_in (lds[j]),
            .pgn     (in_pgn),
            .hit_in  (hchain[j]),
            .hit_out (hchain[j+1])
        );
    end

    always_comb begin
        logic        ok, is_digit, consumed;
        logic [FC_W-1:0] k;
        logic [FC_W-1:0] n;
        link_next = link_reg; len_next = len_reg; xor_next = xor_reg; cs_next = cs_reg;
        dig0_next = dig0_reg; dig1_next = dig1_reg; pre_next = pre_reg; fc_next = fc_reg;
        num_next = num_reg; stop_next = stop_reg; good_next = good_reg; badc_next = badc_reg;
        cerr_next = cerr_reg; nvalid_next = nvalid_reg;
        ev = EV_NONE; hit = 1'b0; feed = 1'b0; line_clear = 1'b0; load_filter = 1'b0;
        start_vec = '0; active_vec = '0;
        ok = 1'b0; consumed = 1'b0; n = '0;
        is_digit = in_c >= CH_ZERO && in_c <= CH_NINE;
        k = (fc_reg > 0) ? fc_reg - 1'b1 : '0;
        if (accept) begin
            unique case (opcode_t'(in_op))
                OP_BYTE: begin
                    if (link_reg != LINK_OFF) begin
                        if (in_c == CH_NL) begin
                            ok = cs_reg == CS_TWO && dig0_reg == hex_up(xor_reg[7:4])
                                 && dig1_reg == hex_up(xor_reg[3:0]);
                            if (!ok) begin
                                cerr_next = cerr_reg + 1'b1;
                                ev = EV_CHECKSUM;
                            end else begin
                                good_next = good_reg + 1'b1;
                                if (pre_reg == 4'(PREFIX_LEN)) begin
                                    link_next = LINK_FILTERED;
                                    if (fc_reg > 0) begin
                                        if (fval[0] == CMD_LOAD_FILTER) begin
                                            n = fc_reg - 1'b1;
                                            if (32'(n) > FILTER_ENTRIES) begin
                                                n = FC_W'(FILTER_ENTRIES);
                                            end
                                            nvalid_next = FN_W'(n);
                                            load_filter = 1'b1;
                                            ev = EV_FILTER;
                                        end else begin
                                            badc_next = badc_reg + 1'b1;
                                            ev = EV_UNKNOWN;
                                        end
                                    end
                                end else begin
                                    badc_next = badc_reg + 1'b1;
                                    ev = EV_UNRECOG;
                                end
                            end
                            line_clear = 1'b1;
                        end else if (in_c >= CH_LOW && in_c <= CH_HIGH && len_reg < LEN_LIMIT) begin
                            if (32'(pre_reg) == 32'(len_reg) && 32'(len_reg) < PREFIX_LEN) begin
                                pre_next = (prefix_char(len_reg[2:0]) == in_c) ?
                                           pre_reg + 1'b1 : PREFIX_BAD;
                            end
                            if (len_reg != '0) begin
                                unique case (cs_reg)
                                    CS_SCAN: begin
                                        if (in_c == CH_STAR) cs_next = CS_STAR;
                                        else if (in_c == CH_DOLLAR) cs_next = CS_DEAD;
                                        else xor_next = xor_reg ^ in_c;
                                    end
                                    CS_STAR: begin dig0_next = in_c; cs_next = CS_ONE; end
                                    CS_ONE:  begin dig1_next = in_c; cs_next = CS_TWO; end
                                    default: cs_next = CS_DEAD;
                                endcase
                                if (fc_reg > 0 && k < FC_MAX && num_reg != NUM_IDLE
                                    && num_reg != NUM_DONE) begin
                                    if (is_digit) begin
                                        feed = 1'b1;
                                        active_vec[k[$clog2(MAX_FIELDS)-1:0]] = 1'b1;
                                        if (num_reg == NUM_LEAD) num_next = NUM_POS;
                                        consumed = 1'b1;
                                    end else if (num_reg == NUM_LEAD && in_c == CH_SPACE) begin
                                        consumed = 1'b1;
                                    end else if (num_reg == NUM_LEAD && in_c == CH_PLUS) begin
                                        num_next = NUM_POS; consumed = 1'b1;
                                    end else if (num_reg == NUM_LEAD && in_c == CH_MINUS) begin
                                        num_next = NUM_NEG; consumed = 1'b1;
                                    end else begin
                                        num_next = NUM_DONE;
                                    end
                                end
                                if (!consumed && !stop_reg) begin
                                    if (in_c == CH_DOLLAR) begin
                                        stop_next = 1'b1;
                                    end else if (in_c == CH_COMMA && fc_reg < FC_MAX) begin
                                        start_vec[fc_reg[$clog2(MAX_FIELDS)-1:0]] = 1'b1;
                                        fc_next = fc_reg + 1'b1;
                                        num_next = NUM_LEAD;
                                        if (fc_reg + 1'b1 >= FC_MAX) stop_next = 1'b1;
                                    end
                                end
                            end
                            len_next = len_reg + 1'b1;
                        end
                    end
                end
                OP_QUERY: begin
                    ev = EV_QUERY;
                    hit = (link_reg == LINK_FILTERED) && hchain[FILTER_ENTRIES];
                end
                OP_CONNECT: begin
                    if (link_reg == LINK_OFF) begin
                        link_next = LINK_PLAIN;
                        good_next = '0; badc_next = '0; cerr_next = '0;
                        line_clear = 1'b1;
                    end
                end
                default: link_next = LINK_OFF;
            endcase
            if (line_clear) begin
                len_next = '0; xor_next = '0; cs_next = CS_SCAN; pre_next = '0;
                fc_next = '0; num_next = NUM_IDLE; stop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= LINK_OFF; len_reg <= '0; xor_reg <= '0; cs_reg <= CS_SCAN;
            pre_reg <= '0; fc_reg <= '0; num_reg <= NUM_IDLE; stop_reg <= 1'b0;
            good_reg <= '0; badc_reg <= '0; cerr_reg <= '0; nvalid_reg <= '0;
        end else begin
            link_reg <= link_next; len_reg <= len_next; xor_reg <= xor_next;
            cs_reg <= cs_next; pre_reg <= pre_next; fc_reg <= fc_next;
            num_reg <= num_next; stop_reg <= stop_next; good_reg <= good_next;
            badc_reg <= badc_next; cerr_reg <= cerr_next; nvalid_reg <= nvalid_next;
        end
        dig0_reg <= dig0_next;
        dig1_reg <= dig1_next;
    end

    logic [103:0] res_word;
    assign res_word = {2'b00, cerr_next, badc_next, good_next, link_next, hit, ev};

    logic         out_valid_reg, skid_valid_reg;
    logic [103:0] out_data_reg, skid_data_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_axis_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= accept;
                    skid_data_reg  <= res_word;
                end else begin
                    out_valid_reg <= accept;
                    out_data_reg  <= res_word;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_word;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(nvalid_reg) <= FILTER_ENTRIES)
        else $error("filter count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fc_reg) <= MAX_FIELDS)
        else $error("field count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");
endmodule
